### sv/upcount_timer_with_watchdog_lock_defines.svh
// -----------------------------------------------------------------------------
// Assertion macros for the up-count timer with watchdog lock
// Shared clocked assertion forms, disabled while reset is held.
// -----------------------------------------------------------------------------
`ifndef UPCOUNT_TIMER_WITH_WATCHDOG_LOCK_DEFINES_SVH
`define UPCOUNT_TIMER_WITH_WATCHDOG_LOCK_DEFINES_SVH

// same-cycle implication
`define UTWL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UTWL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/utwl_pkg.sv
// -----------------------------------------------------------------------------
// utwl_pkg
// Types, register word indexes and codes of the up-count timer with watchdog lock.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package utwl_pkg;

	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_WRITE = 2'd2;

	localparam logic [4:0] REG_CONFIG     = 5'd4;
	localparam logic [4:0] REG_STATUS     = 5'd5;
	localparam logic [4:0] REG_IRQ_STATUS = 5'd6;
	localparam logic [4:0] REG_IRQ_ENABLE = 5'd7;
	localparam logic [4:0] REG_CONTROL    = 5'd9;
	localparam logic [4:0] REG_COUNTER    = 5'd10;
	localparam logic [4:0] REG_LOAD       = 5'd11;
	localparam logic [4:0] REG_PENDING    = 5'd13;
	localparam logic [4:0] REG_START_STOP = 5'd18;

	localparam int CFG_SOFTRESET_BIT = 1;
	localparam int CFG_NOIDLE_BIT    = 3;
	localparam int CTRL_START_BIT    = 0;
	localparam int CTRL_AUTORELOAD_BIT = 1;
	localparam int IRQ_GP_OVF_BIT    = 1;
	localparam int IRQ_DOG_OVF_BIT   = 0;

	localparam logic [15:0] MAGIC_OFF1 = 16'haaaa;
	localparam logic [15:0] MAGIC_OFF2 = 16'h5555;
	localparam logic [15:0] MAGIC_ON1  = 16'hbbbb;
	localparam logic [15:0] MAGIC_ON2  = 16'h4444;

	localparam logic [1:0] SEQ_NONE    = 2'd0;
	localparam logic [1:0] SEQ_SAW_OFF = 2'd1;
	localparam logic [1:0] SEQ_SAW_ON  = 2'd2;

	localparam int TDATA_W = 40;
	localparam int TUSER_W = 2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [4:0]  reg_word;
		logic [31:0] write_value;
	} item_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic        irq_level;
		logic        overflow_pulse;
	} result_t;

endpackage

### sv/utwl_core.sv
// -----------------------------------------------------------------------------
// utwl_core
// Timer registers, tick counter, magic start-stop sequence and read mux.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "upcount_timer_with_watchdog_lock_defines.svh"

module utwl_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	input  logic              accept,
	input  utwl_pkg::item_t   item,
	output utwl_pkg::result_t result
);

	logic        kind_q;
	logic [31:0] count_q;
	logic [31:0] reload_q;
	logic [1:0]  ctrl_q;
	logic [1:0]  flags_q;
	logic [1:0]  enables_q;
	logic        idle_q;
	logic        dog_q;
	logic [1:0]  seq_q;
	logic [15:0] ss_word_q;

	logic [31:0] count_d;
	logic [31:0] reload_d;
	logic [1:0]  ctrl_d;
	logic [1:0]  flags_d;
	logic [1:0]  enables_d;
	logic        idle_d;
	logic        dog_d;
	logic [1:0]  seq_d;
	logic [15:0] ss_word_d;
	logic [31:0] rd;
	logic        pulse;

	always_comb begin
		logic        running;
		logic [15:0] lo;
		count_d   = count_q;
		reload_d  = reload_q;
		ctrl_d    = ctrl_q;
		flags_d   = flags_q;
		enables_d = enables_q;
		idle_d    = idle_q;
		dog_d     = dog_q;
		seq_d     = seq_q;
		ss_word_d = ss_word_q;
		rd        = 32'd0;
		pulse     = 1'b0;
		running   = kind_q ? dog_q : ctrl_q[utwl_pkg::CTRL_START_BIT];
		lo        = item.write_value[15:0];
		case (item.mode)
			utwl_pkg::MODE_TICK: begin
				if (running) begin
					if (count_q != 32'hffff_ffff) begin
						count_d = count_q + 32'd1;
					end else begin
						pulse = 1'b1;
						if (kind_q || ctrl_q[utwl_pkg::CTRL_AUTORELOAD_BIT]) begin
							count_d = reload_q;
						end else begin
							count_d = 32'd0;
							ctrl_d[utwl_pkg::CTRL_START_BIT] = 1'b0;
						end
						if (kind_q) begin
							flags_d[utwl_pkg::IRQ_DOG_OVF_BIT] = 1'b1;
						end else begin
							flags_d[utwl_pkg::IRQ_GP_OVF_BIT] = 1'b1;
						end
					end
				end
			end
			utwl_pkg::MODE_READ: begin
				case (item.reg_word)
					utwl_pkg::REG_CONFIG:     rd = {28'd0, idle_q, 3'd0};
					utwl_pkg::REG_STATUS:     rd = 32'd1;
					utwl_pkg::REG_IRQ_STATUS: rd = {30'd0, flags_q};
					utwl_pkg::REG_IRQ_ENABLE: rd = {30'd0, enables_q};
					utwl_pkg::REG_CONTROL:    rd = {30'd0, ctrl_q};
					utwl_pkg::REG_COUNTER:    rd = count_q;
					utwl_pkg::REG_LOAD:       rd = reload_q;
					utwl_pkg::REG_START_STOP: rd = {16'd0, ss_word_q};
					default:                  rd = 32'd0;
				endcase
			end
			utwl_pkg::MODE_WRITE: begin
				case (item.reg_word)
					utwl_pkg::REG_CONFIG: begin
						if (item.write_value[utwl_pkg::CFG_SOFTRESET_BIT]) begin
							count_d   = 32'd0;
							reload_d  = 32'd0;
							ctrl_d    = 2'd0;
							flags_d   = 2'd0;
							enables_d = 2'd0;
							dog_d     = 1'b1;
							seq_d     = utwl_pkg::SEQ_NONE;
							ss_word_d = 16'd0;
						end
						idle_d = item.write_value[utwl_pkg::CFG_NOIDLE_BIT];
					end
					utwl_pkg::REG_IRQ_STATUS: flags_d   = flags_q & ~item.write_value[1:0];
					utwl_pkg::REG_IRQ_ENABLE: enables_d = item.write_value[1:0];
					utwl_pkg::REG_CONTROL:    ctrl_d    = item.write_value[1:0];
					utwl_pkg::REG_COUNTER:    count_d   = item.write_value;
					utwl_pkg::REG_LOAD:       reload_d  = item.write_value;
					utwl_pkg::REG_START_STOP: begin
						ss_word_d = lo;
						if (kind_q) begin
							if (lo == utwl_pkg::MAGIC_OFF1) begin
								seq_d = utwl_pkg::SEQ_SAW_OFF;
							end else if (lo == utwl_pkg::MAGIC_ON1) begin
								seq_d = utwl_pkg::SEQ_SAW_ON;
							end else if (lo == utwl_pkg::MAGIC_OFF2 &&
									seq_q == utwl_pkg::SEQ_SAW_OFF) begin
								dog_d = 1'b0;
								seq_d = utwl_pkg::SEQ_NONE;
							end else if (lo == utwl_pkg::MAGIC_ON2 &&
									seq_q == utwl_pkg::SEQ_SAW_ON) begin
								dog_d = 1'b1;
								seq_d = utwl_pkg::SEQ_NONE;
							end else begin
								seq_d = utwl_pkg::SEQ_NONE;
							end
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	assign result.read_value     = rd;
	assign result.irq_level      = |(flags_d & enables_d);
	assign result.overflow_pulse = pulse;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q    <= 1'b0;
			count_q   <= 32'd0;
			reload_q  <= 32'd0;
			ctrl_q    <= 2'd0;
			flags_q   <= 2'd0;
			enables_q <= 2'd0;
			idle_q    <= 1'b0;
			dog_q     <= 1'b1;
			seq_q     <= utwl_pkg::SEQ_NONE;
			ss_word_q <= 16'd0;
		end else begin
			if (cfg_we) begin
				kind_q <= cfg_wdata;
			end
			if (accept) begin
				count_q   <= count_d;
				reload_q  <= reload_d;
				ctrl_q    <= ctrl_d;
				flags_q   <= flags_d;
				enables_q <= enables_d;
				idle_q    <= idle_d;
				dog_q     <= dog_d;
				seq_q     <= seq_d;
				ss_word_q <= ss_word_d;
			end
		end
	end

	`UTWL_ASSERT_NEXT(a_count_holds, !accept, $stable(count_q), "counter moved without a word")
	`UTWL_ASSERT_NEXT(a_ovf_flags, accept && result.overflow_pulse, flags_q != 2'd0,
		"overflow did not set a status bit")

endmodule

### sv/utwl_out_buf.sv
// -----------------------------------------------------------------------------
// utwl_out_buf
// Result register with a skid stage toward the master side.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "upcount_timer_with_watchdog_lock_defines.svh"

module utwl_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  utwl_pkg::result_t push_data,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output utwl_pkg::result_t out_data
);

	logic              out_valid_q;
	logic              skid_valid_q;
	utwl_pkg::result_t out_q;
	utwl_pkg::result_t skid_q;
	logic              pop;

	assign pop       = out_valid_q & out_ready;
	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (pop) begin
					skid_valid_q <= 1'b0;
				end
			end else if (push) begin
				if (!out_valid_q || pop) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_q <= push_data;
			end else begin
				skid_q <= push_data;
			end
		end
	end

	`UTWL_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q, "skid word ahead of output word")
	`UTWL_ASSERT_NEXT(a_stall_to_skid, push && out_valid_q && !pop, skid_valid_q,
		"stalled word not held in skid stage")

endmodule

### sv/upcount_timer_with_watchdog_lock.sv
// Results are registered in utwl_out_buf before they appear on m_axis.
// Throughput: one word per clock while s_axis_tready is high; all kinds take one pass.
// A skid stage keeps s_axis_tready high while one finished result waits on m_axis.
// Reset: all but data registers reset at once; the watchdog runs from reset, no sweep.
// -----------------------------------------------------------------------------
// upcount_timer_with_watchdog_lock
// Stream wrapper: unpacks input words, runs the timer core, buffers results.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module upcount_timer_with_watchdog_lock (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_wdata,     // timer_kind
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [utwl_pkg::TDATA_W-1:0] s_axis_tdata,  // reg_word, write_value, zero pad
	input  logic [utwl_pkg::TUSER_W-1:0] s_axis_tuser,  // mode
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [utwl_pkg::TDATA_W-1:0] m_axis_tdata   // read_value, irq_level,
	                                                    // overflow_pulse, zero pad
);

	utwl_pkg::item_t   item;
	utwl_pkg::result_t core_res;
	utwl_pkg::result_t out_res;
	logic              accept;

	assign item.mode        = s_axis_tuser;
	assign item.reg_word    = s_axis_tdata[4:0];
	assign item.write_value = s_axis_tdata[36:5];
	assign accept           = s_axis_tvalid & s_axis_tready;

	utwl_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.accept   (accept),
		.item     (item),
		.result   (core_res)
	);

	utwl_out_buf u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_data(core_res),
		.in_ready (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data (out_res)
	);

	assign m_axis_tdata = {6'd0, out_res.overflow_pulse, out_res.irq_level, out_res.read_value};

endmodule

### tb/testbench.sv
// -----------------------------------------------------------------------------
// testbench
// Stream-level check of the up-count timer with watchdog lock: a directed
// table, then random phases in both timer kinds, all but one with random idling and
// back-pressure, each result word compared against its pinned value or a cycle-free timer model.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam bit         KIND_GP     = 1'b0;
	localparam bit         KIND_DOG    = 1'b1;
	localparam int         PHASE_WORDS = 138;
	localparam int         STALL_LIMIT = 5000;
	localparam int         HOLD_CYCLES = 120;

	typedef struct {
		bit                kind;
		logic [1:0]        mode;
		logic [4:0]        reg_word;
		logic [31:0]       value;
		bit                pinned;
		utwl_pkg::result_t want;
	} stim_row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic                           cfg_wdata;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	logic [utwl_pkg::TDATA_W-1:0]   s_axis_tdata;
	logic [utwl_pkg::TUSER_W-1:0]   s_axis_tuser;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready;
	logic [utwl_pkg::TDATA_W-1:0]   m_axis_tdata;

	// timer model state
	bit          kind      = KIND_GP;
	logic [31:0] cnt       = '0;
	logic [31:0] load_val  = '0;
	logic [1:0]  ctrl      = '0;
	logic [1:0]  flags     = '0;
	logic [1:0]  enables   = '0;
	logic        noidle    = 1'b0;
	logic        dog_on    = 1'b1;
	logic [1:0]  seq       = utwl_pkg::SEQ_NONE;
	logic [15:0] ss_word   = '0;

	utwl_pkg::result_t pending_results[$];
	stim_row_t         dir_rows[$];
	utwl_pkg::result_t want_now;
	utwl_pkg::result_t got_now;
	bit                pin_now;
	utwl_pkg::result_t pin_want;
	bit          tx_idle_on;
	bit          rx_idle_on;
	int          hold_reqs;
	int          hold_seen;
	int          hold_left;
	int          fails;
	int          idle_cycles;
	int          words_sent;
	int          results_seen;
	int          wraps_seen;
	int          phases_run;

	upcount_timer_with_watchdog_lock u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic utwl_pkg::result_t timer_step(logic [1:0] m, logic [4:0] r,
		logic [31:0] v);
		utwl_pkg::result_t res;
		logic running;
		res = '0;
		case (m)
		utwl_pkg::MODE_TICK: begin
			running = kind ? dog_on : ctrl[utwl_pkg::CTRL_START_BIT];
			if (running) begin
				if (cnt != '1) begin
					cnt = cnt + 32'd1;
				end else begin
					if (kind || ctrl[utwl_pkg::CTRL_AUTORELOAD_BIT]) begin
						cnt = load_val;
					end else begin
						cnt = '0;
						ctrl[utwl_pkg::CTRL_START_BIT] = 1'b0;
					end
					if (kind) flags[utwl_pkg::IRQ_DOG_OVF_BIT] = 1'b1;
					else flags[utwl_pkg::IRQ_GP_OVF_BIT] = 1'b1;
					res.overflow_pulse = 1'b1;
				end
			end
		end
		utwl_pkg::MODE_READ: begin
			case (r)
			utwl_pkg::REG_CONFIG:
				res.read_value = 32'(noidle) << utwl_pkg::CFG_NOIDLE_BIT;
			utwl_pkg::REG_STATUS:     res.read_value = 32'd1;
			utwl_pkg::REG_IRQ_STATUS: res.read_value = 32'(flags);
			utwl_pkg::REG_IRQ_ENABLE: res.read_value = 32'(enables);
			utwl_pkg::REG_CONTROL:    res.read_value = 32'(ctrl);
			utwl_pkg::REG_COUNTER:    res.read_value = cnt;
			utwl_pkg::REG_LOAD:       res.read_value = load_val;
			utwl_pkg::REG_START_STOP: res.read_value = 32'(ss_word);
			default:                  res.read_value = '0;
			endcase
		end
		utwl_pkg::MODE_WRITE: begin
			case (r)
			utwl_pkg::REG_CONFIG: begin
				if (v[utwl_pkg::CFG_SOFTRESET_BIT]) begin
					cnt = '0;
					load_val = '0;
					ctrl = '0;
					flags = '0;
					enables = '0;
					dog_on = 1'b1;
					seq = utwl_pkg::SEQ_NONE;
					ss_word = '0;
				end
				noidle = v[utwl_pkg::CFG_NOIDLE_BIT];
			end
			utwl_pkg::REG_IRQ_STATUS: flags = flags & ~v[1:0];
			utwl_pkg::REG_IRQ_ENABLE: enables = v[1:0];
			utwl_pkg::REG_CONTROL:    ctrl = v[1:0];
			utwl_pkg::REG_COUNTER:    cnt = v;
			utwl_pkg::REG_LOAD:       load_val = v;
			utwl_pkg::REG_START_STOP: begin
				ss_word = v[15:0];
				if (kind) begin
					if (v[15:0] == utwl_pkg::MAGIC_OFF1) begin
						seq = utwl_pkg::SEQ_SAW_OFF;
					end else if (v[15:0] == utwl_pkg::MAGIC_ON1) begin
						seq = utwl_pkg::SEQ_SAW_ON;
					end else if (v[15:0] == utwl_pkg::MAGIC_OFF2 &&
							seq == utwl_pkg::SEQ_SAW_OFF) begin
						dog_on = 1'b0;
						seq = utwl_pkg::SEQ_NONE;
					end else if (v[15:0] == utwl_pkg::MAGIC_ON2 &&
							seq == utwl_pkg::SEQ_SAW_ON) begin
						dog_on = 1'b1;
						seq = utwl_pkg::SEQ_NONE;
					end else begin
						seq = utwl_pkg::SEQ_NONE;
					end
				end
			end
			default: ;
			endcase
		end
		default: ;
		endcase
		res.irq_level = |(flags & enables);
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		fails++;
		$display("%0t mismatch: %s got 0x%08h want 0x%08h", $realtime, what, got, want);
	endtask

	// checker, model and stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", STALL_LIMIT);
				$display("RESULT: ERROR");
				$finish;
			end
			if (cfg_we)
				kind = cfg_wdata;
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				got_now.read_value = m_axis_tdata[31:0];
				got_now.irq_level = m_axis_tdata[32];
				got_now.overflow_pulse = m_axis_tdata[33];
				if (got_now.overflow_pulse)
					wraps_seen++;
				if (pending_results.size() == 0) begin
					report_mismatch("result word with none pending", m_axis_tdata[31:0], '0);
				end else begin
					want_now = pending_results.pop_front();
					if (got_now.read_value !== want_now.read_value)
						report_mismatch("read_value", got_now.read_value,
							want_now.read_value);
					if (got_now.irq_level !== want_now.irq_level)
						report_mismatch("irq_level", 32'(got_now.irq_level),
							32'(want_now.irq_level));
					if (got_now.overflow_pulse !== want_now.overflow_pulse)
						report_mismatch("overflow_pulse", 32'(got_now.overflow_pulse),
							32'(want_now.overflow_pulse));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				want_now = timer_step(s_axis_tuser, s_axis_tdata[4:0], s_axis_tdata[36:5]);
				pending_results.push_back(pin_now ? pin_want : want_now);
			end
		end
	end

	// receiver: random stalls plus requested long hold-offs
	always @(negedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			m_axis_tready = 1'b0;
			hold_left--;
		end else begin
			m_axis_tready = !(rx_idle_on && $urandom_range(0, 99) < 7);
		end
	end

	task automatic send_word(input logic [1:0] m, input logic [4:0] r, input logic [31:0] v,
		input bit pin, input utwl_pkg::result_t want);
		if (tx_idle_on && $urandom_range(0, 99) < 7) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser = m;
		s_axis_tdata = {3'b000, v, r};
		pin_now = pin;
		pin_want = want;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		words_sent++;
	endtask

	task automatic set_kind(input bit k);
		while (pending_results.size() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
		cfg_wdata = k;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic row(input bit k, input logic [1:0] m, input logic [4:0] r,
		input logic [31:0] v, input bit pin, input logic [31:0] rd, input bit irq,
		input bit pulse);
		stim_row_t e;
		e.kind = k;
		e.mode = m;
		e.reg_word = r;
		e.value = v;
		e.pinned = pin;
		e.want.read_value = rd;
		e.want.irq_level = irq;
		e.want.overflow_pulse = pulse;
		dir_rows.push_back(e);
	endtask

	function automatic logic [4:0] known_reg();
		case ($urandom_range(0, 8))
		0:       return utwl_pkg::REG_CONFIG;
		1:       return utwl_pkg::REG_STATUS;
		2:       return utwl_pkg::REG_IRQ_STATUS;
		3:       return utwl_pkg::REG_IRQ_ENABLE;
		4:       return utwl_pkg::REG_CONTROL;
		5:       return utwl_pkg::REG_COUNTER;
		6:       return utwl_pkg::REG_LOAD;
		7:       return utwl_pkg::REG_PENDING;
		default: return utwl_pkg::REG_START_STOP;
		endcase
	endfunction

	task automatic random_word();
		int pick;
		logic [31:0] v;
		logic [31:0] v2;
		pick = $urandom_range(0, 99);
		v = $urandom();
		v2 = $urandom();
		if (pick < 30) begin
			send_word(utwl_pkg::MODE_TICK, 5'($urandom_range(0, 31)), v, 1'b0, '0);
		end else if (pick < 40) begin
			send_word(utwl_pkg::MODE_READ, known_reg(), v, 1'b0, '0);
		end else if (pick < 50) begin
			send_word(utwl_pkg::MODE_READ, 5'($urandom_range(0, 31)), v, 1'b0, '0);
		end else if (pick < 60) begin
			// start-stop pair, mostly a clean sequence
			case ($urandom_range(0, 4))
			0: begin v[15:0] = utwl_pkg::MAGIC_OFF1; v2[15:0] = utwl_pkg::MAGIC_OFF2; end
			1: begin v[15:0] = utwl_pkg::MAGIC_ON1;  v2[15:0] = utwl_pkg::MAGIC_ON2;  end
			2: begin v[15:0] = utwl_pkg::MAGIC_ON1;  v2[15:0] = utwl_pkg::MAGIC_ON2;  end
			3: begin v[15:0] = utwl_pkg::MAGIC_OFF1; v2[15:0] = utwl_pkg::MAGIC_ON2;  end
			default: begin v[15:0] = utwl_pkg::MAGIC_ON1; v2[15:0] = utwl_pkg::MAGIC_OFF2; end
			endcase
			if ($urandom_range(0, 9) == 0)
				v[15:0] = 16'($urandom());
			send_word(utwl_pkg::MODE_WRITE, utwl_pkg::REG_START_STOP, v, 1'b0, '0);
			send_word(utwl_pkg::MODE_WRITE, utwl_pkg::REG_START_STOP, v2, 1'b0, '0);
		end else if (pick < 70) begin
			if ($urandom_range(0, 9) < 7)
				v = 32'hffff_ffff - 32'($urandom_range(0, 6));
			send_word(utwl_pkg::MODE_WRITE, utwl_pkg::REG_COUNTER, v, 1'b0, '0);
		end else if (pick < 75) begin
			if ($urandom_range(0, 1) == 0)
				v = 32'hffff_ffff - 32'($urandom_range(0, 3));
			send_word(utwl_pkg::MODE_WRITE, utwl_pkg::REG_LOAD, v, 1'b0, '0);
		end else if (pick < 83) begin
			send_word(utwl_pkg::MODE_WRITE, utwl_pkg::REG_CONTROL, v, 1'b0, '0);
		end else if (pick < 88) begin
			send_word(utwl_pkg::MODE_WRITE, utwl_pkg::REG_IRQ_ENABLE, v, 1'b0, '0);
		end else if (pick < 93) begin
			send_word(utwl_pkg::MODE_WRITE, utwl_pkg::REG_IRQ_STATUS, v, 1'b0, '0);
		end else if (pick < 95) begin
			send_word(utwl_pkg::MODE_WRITE, utwl_pkg::REG_CONFIG, v, 1'b0, '0);
		end else if (pick < 97) begin
			send_word(MODE_UNUSED, 5'($urandom_range(0, 31)), v, 1'b0, '0);
		end else begin
			send_word(utwl_pkg::MODE_WRITE, 5'($urandom_range(0, 31)), v, 1'b0, '0);
		end
	endtask

	initial begin
		bit phase_kind;
		int start_count;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		pin_now = 1'b0;
		pin_want = '0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;

		// kind, mode, register, value, pin, read_value, irq, pulse
		row(KIND_GP, utwl_pkg::MODE_READ, utwl_pkg::REG_STATUS, 32'h0, 1, 32'd1, 0, 0);
		row(KIND_GP, utwl_pkg::MODE_READ, utwl_pkg::REG_PENDING, 32'h0, 1, 32'd0, 0, 0);
		row(KIND_GP, MODE_UNUSED, utwl_pkg::REG_PENDING, 32'hffffffff, 1, 32'd0, 0, 0);
		row(KIND_GP, utwl_pkg::MODE_WRITE, utwl_pkg::REG_COUNTER, 32'hffffffff, 1, 32'd0, 0, 0);
		row(KIND_GP, utwl_pkg::MODE_WRITE, utwl_pkg::REG_IRQ_ENABLE, 32'hffffffff, 1, 32'd0, 0, 0);
		row(KIND_GP, utwl_pkg::MODE_WRITE, utwl_pkg::REG_CONTROL, 32'h1, 0, 32'd0, 0, 0);
		row(KIND_GP, utwl_pkg::MODE_TICK, utwl_pkg::REG_STATUS, 32'h0, 1, 32'd0, 1, 1);
		row(KIND_GP, utwl_pkg::MODE_READ, utwl_pkg::REG_CONTROL, 32'h0, 1, 32'd0, 1, 0);
		row(KIND_GP, utwl_pkg::MODE_WRITE, utwl_pkg::REG_IRQ_STATUS, 32'hffffffff, 1, 32'd0, 0, 0);
		row(KIND_GP, utwl_pkg::MODE_WRITE, utwl_pkg::REG_LOAD, 32'h80000000, 0, 32'd0, 0, 0);
		row(KIND_GP, utwl_pkg::MODE_WRITE, utwl_pkg::REG_COUNTER, 32'hffffffff, 0, 32'd0, 0, 0);
		row(KIND_GP, utwl_pkg::MODE_WRITE, utwl_pkg::REG_CONTROL, 32'hffffffff, 0, 32'd0, 0, 0);
		row(KIND_GP, utwl_pkg::MODE_TICK, 5'd31, 32'hffffffff, 1, 32'd0, 1, 1);
		row(KIND_GP, utwl_pkg::MODE_READ, utwl_pkg::REG_COUNTER, 32'h0, 1, 32'h80000000, 1, 0);
		row(KIND_GP, utwl_pkg::MODE_WRITE, utwl_pkg::REG_START_STOP, 32'hffffaaaa, 0, 32'd0, 0, 0);
		row(KIND_GP, utwl_pkg::MODE_READ, utwl_pkg::REG_START_STOP, 32'h0, 1, 32'haaaa, 1, 0);
		row(KIND_GP, utwl_pkg::MODE_WRITE, utwl_pkg::REG_CONFIG, 32'ha, 1, 32'd0, 0, 0);
		row(KIND_GP, utwl_pkg::MODE_READ, utwl_pkg::REG_CONFIG, 32'h0, 1, 32'd8, 0, 0);
		row(KIND_DOG, utwl_pkg::MODE_TICK, utwl_pkg::REG_COUNTER, 32'h0, 0, 32'd0, 0, 0);
		row(KIND_DOG, utwl_pkg::MODE_WRITE, utwl_pkg::REG_START_STOP, 32'haaaa, 0, 32'd0, 0, 0);
		row(KIND_DOG, utwl_pkg::MODE_WRITE, utwl_pkg::REG_START_STOP, 32'h5555, 0, 32'd0, 0, 0);
		row(KIND_DOG, utwl_pkg::MODE_TICK, utwl_pkg::REG_COUNTER, 32'h0, 0, 32'd0, 0, 0);
		row(KIND_DOG, utwl_pkg::MODE_READ, utwl_pkg::REG_COUNTER, 32'h0, 1, 32'd1, 0, 0);
		row(KIND_DOG, utwl_pkg::MODE_WRITE, utwl_pkg::REG_START_STOP, 32'hbbbb, 0, 32'd0, 0, 0);
		row(KIND_DOG, utwl_pkg::MODE_WRITE, utwl_pkg::REG_START_STOP, 32'h4444, 0, 32'd0, 0, 0);
		row(KIND_DOG, utwl_pkg::MODE_TICK, utwl_pkg::REG_COUNTER, 32'h0, 0, 32'd0, 0, 0);
		row(KIND_DOG, utwl_pkg::MODE_READ, utwl_pkg::REG_COUNTER, 32'h0, 0, 32'd0, 0, 0);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		set_kind(KIND_GP);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind != kind)
				set_kind(dir_rows[i].kind);
			send_word(dir_rows[i].mode, dir_rows[i].reg_word, dir_rows[i].value,
				dir_rows[i].pinned, dir_rows[i].want);
		end

		for (int phase = 0; phase < 6; phase++) begin
			phase_kind = (phase == 0 || phase == 2 || phase == 5) ? KIND_DOG : KIND_GP;
			// drain before each change, which also pauses the sender
			set_kind(phase_kind);
			tx_idle_on = (phase != 2);
			rx_idle_on = (phase != 2);
			if (phase == 1)
				hold_reqs++;
			start_count = words_sent;
			while (words_sent - start_count < PHASE_WORDS)
				random_word();
			phases_run++;
		end

		while (pending_results.size() != 0) @(negedge clk);
		repeat (4) @(posedge clk);
		$display("sent %0d words over %0d random phases in both timer kinds", words_sent,
			phases_run);
		$display("checked %0d result words, %0d counter wraps", results_seen, wraps_seen);
		if (fails == 0 && pending_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
